### rtl/core/asp_pkg.sv
// Shared types, codes and defaults for the archive stream parser.
package asp_pkg;

    localparam int MAGIC_BYTES_DEFAULT = 4;
    localparam int OFFSET_BITS_DEFAULT = 32;

    localparam int RES_FIFO_DEPTH = 4;
    localparam int RES_PTR_BITS   = $clog2(RES_FIFO_DEPTH);
    localparam int RES_CNT_BITS   = $clog2(RES_FIFO_DEPTH + 1);

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MAGIC_WORD       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXPECTED_VERSION = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENTRY_LIMIT      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATH_LIMIT       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOTAL_SIZE       = 3'd4;

    localparam logic [31:0] MAGIC_WORD_RESET       = 32'd0;
    localparam logic [31:0] EXPECTED_VERSION_RESET = 32'd1;
    localparam logic [15:0] ENTRY_LIMIT_RESET      = 16'd64;
    localparam logic [15:0] PATH_LIMIT_RESET       = 16'd256;
    localparam logic [31:0] TOTAL_SIZE_RESET       = 32'd0;

    localparam logic [2:0] EV_PATH_BYTE     = 3'd0;
    localparam logic [2:0] EV_CONTENT_START = 3'd1;
    localparam logic [2:0] EV_CONTENT_BYTE  = 3'd2;
    localparam logic [2:0] EV_ACCEPT        = 3'd3;
    localparam logic [2:0] EV_REJECT        = 3'd4;

    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_SHORT       = 4'd1;
    localparam logic [3:0] ERR_MAGIC       = 4'd2;
    localparam logic [3:0] ERR_VERSION     = 4'd3;
    localparam logic [3:0] ERR_COUNT       = 4'd4;
    localparam logic [3:0] ERR_PATHLEN_CUT = 4'd5;
    localparam logic [3:0] ERR_PATH        = 4'd6;
    localparam logic [3:0] ERR_CONTLEN_CUT = 4'd7;
    localparam logic [3:0] ERR_CONTENT     = 4'd8;

    typedef struct packed {
        logic [2:0]  event_code;
        logic [15:0] entry;
        logic [7:0]  value;
        logic [31:0] offset;
        logic [63:0] length;
        logic [3:0]  error;
        logic        last;
    } res_t;

endpackage

### rtl/core/archive_stream_parser.sv
// Archive stream parser: byte-wide header, path and content walker.
// Results are registered: each is written into the result queue when its byte is accepted.
// Throughput: one byte per cycle; a byte gives at most two results, which
// drain through a four-entry result queue, and input stalls only when fewer
// than two queue slots are free.
// Reset: rst_n clears the parse state, the queue and the registers to their
// defaults at once; no clearing pass.
module archive_stream_parser #(
    parameter int MAGIC_BYTES = asp_pkg::MAGIC_BYTES_DEFAULT,
    parameter int OFFSET_BITS = asp_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [asp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [asp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           data_byte,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [2:0]                           event_res,
    output logic [15:0]                          entry_index,
    output logic [7:0]                           byte_value,
    output logic [31:0]                          byte_offset,
    output logic [63:0]                          content_length,
    output logic [3:0]                           error_code,
    output logic                                 last_of_run
);

    localparam logic [63:0] OFF_MASK = {64{1'b1}} >> (64 - OFFSET_BITS);

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_VERSION,
        PH_COUNT,
        PH_PATHLEN,
        PH_PATH,
        PH_CONTLEN,
        PH_CONTENT,
        PH_DONE
    } phase_t;

    logic [31:0] magic_reg;
    logic [31:0] version_reg;
    logic [15:0] entry_limit_reg;
    logic [15:0] path_limit_reg;
    logic [31:0] total_size_reg;

    phase_t                 phase_reg, phase_next;
    logic [2:0]             fbc_reg, fbc_next;
    logic [63:0]            shift_reg, shift_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [15:0]            entry_reg, entry_next;
    logic [31:0]            declared_reg, declared_next;
    logic [15:0]            path_rem_reg, path_rem_next;
    logic [63:0]            cont_rem_reg, cont_rem_next;

    logic [OFFSET_BITS-1:0] off_inc;
    logic [63:0]            pos64;
    logic [63:0]            inc64;
    logic [63:0]            eff_size;
    logic [63:0]            space;
    logic [63:0]            gathered;
    logic [15:0]            entry_inc;
    logic                   entry_last;
    logic                   take;

    asp_pkg::res_t prim, term;
    logic          prim_valid, term_valid;

    asp_pkg::res_t                       fifo_mem [asp_pkg::RES_FIFO_DEPTH];
    logic [asp_pkg::RES_PTR_BITS-1:0]    wr_ptr_reg;
    logic [asp_pkg::RES_PTR_BITS-1:0]    rd_ptr_reg;
    logic [asp_pkg::RES_CNT_BITS-1:0]    count_reg;
    logic [asp_pkg::RES_CNT_BITS-1:0]    push_cnt;
    logic                                pop;
    asp_pkg::res_t                       push_first;
    asp_pkg::res_t                       head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg       <= asp_pkg::MAGIC_WORD_RESET;
            version_reg     <= asp_pkg::EXPECTED_VERSION_RESET;
            entry_limit_reg <= asp_pkg::ENTRY_LIMIT_RESET;
            path_limit_reg  <= asp_pkg::PATH_LIMIT_RESET;
            total_size_reg  <= asp_pkg::TOTAL_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                asp_pkg::REG_MAGIC_WORD:       magic_reg       <= cfg_data;
                asp_pkg::REG_EXPECTED_VERSION: version_reg     <= cfg_data;
                asp_pkg::REG_ENTRY_LIMIT:      entry_limit_reg <= cfg_data[15:0];
                asp_pkg::REG_PATH_LIMIT:       path_limit_reg  <= cfg_data[15:0];
                asp_pkg::REG_TOTAL_SIZE:       total_size_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign take      = in_valid && in_ready;
    assign off_inc   = off_reg + 1'b1;
    assign pos64     = 64'(off_reg);
    assign inc64     = 64'(off_inc);
    assign eff_size  = {32'd0, total_size_reg} & OFF_MASK;
    assign space     = (eff_size > inc64) ? (eff_size - inc64) : 64'd0;
    assign entry_inc = entry_reg + 16'd1;
    assign entry_last = ({16'd0, entry_inc} == declared_reg);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            gathered[8*i +: 8] = (fbc_reg == 3'(i)) ? data_byte : shift_reg[8*i +: 8];
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        fbc_next      = fbc_reg;
        shift_next    = shift_reg;
        off_next      = off_reg;
        entry_next    = entry_reg;
        declared_next = declared_reg;
        path_rem_next = path_rem_reg;
        cont_rem_next = cont_rem_reg;

        prim_valid       = 1'b0;
        prim.event_code  = asp_pkg::EV_PATH_BYTE;
        prim.entry       = entry_reg;
        prim.value       = data_byte;
        prim.offset      = pos64[31:0];
        prim.length      = 64'd0;
        prim.error       = asp_pkg::ERR_NONE;
        prim.last        = 1'b1;

        term_valid       = 1'b0;
        term.event_code  = asp_pkg::EV_REJECT;
        term.entry       = entry_reg;
        term.value       = 8'd0;
        term.offset      = inc64[31:0];
        term.length      = 64'd0;
        term.error       = asp_pkg::ERR_NONE;
        term.last        = 1'b1;

        if (take && phase_reg != PH_DONE)
        begin
            off_next = off_inc;
            unique case (phase_reg)
                PH_MAGIC:
                begin
                    if (eff_size < 64'(MAGIC_BYTES + 8))
                    begin
                        term_valid = 1'b1;
                        term.error = asp_pkg::ERR_SHORT;
                    end
                    else if (magic_reg[8*fbc_reg[1:0] +: 8] != data_byte)
                    begin
                        term_valid = 1'b1;
                        term.error = asp_pkg::ERR_MAGIC;
                    end
                    else if (fbc_reg == 3'(MAGIC_BYTES - 1))
                    begin
                        fbc_next   = 3'd0;
                        shift_next = 64'd0;
                        phase_next = PH_VERSION;
                    end
                    else
                    begin
                        fbc_next = fbc_reg + 3'd1;
                    end
                end
                PH_VERSION:
                begin
                    if (fbc_reg == 3'd3)
                    begin
                        fbc_next   = 3'd0;
                        shift_next = 64'd0;
                        if (gathered[31:0] != version_reg)
                        begin
                            term_valid = 1'b1;
                            term.error = asp_pkg::ERR_VERSION;
                        end
                        else
                        begin
                            phase_next = PH_COUNT;
                        end
                    end
                    else
                    begin
                        fbc_next   = fbc_reg + 3'd1;
                        shift_next = gathered;
                    end
                end
                PH_COUNT:
                begin
                    if (fbc_reg == 3'd3)
                    begin
                        fbc_next      = 3'd0;
                        shift_next    = 64'd0;
                        declared_next = gathered[31:0];
                        if (gathered[31:0] > {16'd0, entry_limit_reg})
                        begin
                            term_valid = 1'b1;
                            term.error = asp_pkg::ERR_COUNT;
                        end
                        else if (gathered[31:0] == 32'd0)
                        begin
                            term_valid      = 1'b1;
                            term.event_code = asp_pkg::EV_ACCEPT;
                        end
                        else if (space < 64'd2)
                        begin
                            term_valid = 1'b1;
                            term.error = asp_pkg::ERR_PATHLEN_CUT;
                        end
                        else
                        begin
                            phase_next = PH_PATHLEN;
                        end
                    end
                    else
                    begin
                        fbc_next   = fbc_reg + 3'd1;
                        shift_next = gathered;
                    end
                end
                PH_PATHLEN:
                begin
                    if (fbc_reg == 3'd1)
                    begin
                        fbc_next      = 3'd0;
                        shift_next    = 64'd0;
                        if (gathered[15:0] >= path_limit_reg
                            || {48'd0, gathered[15:0]} > space)
                        begin
                            term_valid = 1'b1;
                            term.error = asp_pkg::ERR_PATH;
                        end
                        else
                        begin
                            path_rem_next = gathered[15:0];
                            if (gathered[15:0] != 16'd0)
                            begin
                                phase_next = PH_PATH;
                            end
                            else if (space < 64'd8)
                            begin
                                term_valid = 1'b1;
                                term.error = asp_pkg::ERR_CONTLEN_CUT;
                            end
                            else
                            begin
                                phase_next = PH_CONTLEN;
                            end
                        end
                    end
                    else
                    begin
                        fbc_next   = fbc_reg + 3'd1;
                        shift_next = gathered;
                    end
                end
                PH_PATH:
                begin
                    prim_valid      = 1'b1;
                    prim.event_code = asp_pkg::EV_PATH_BYTE;
                    path_rem_next   = path_rem_reg - 16'd1;
                    if (path_rem_reg == 16'd1)
                    begin
                        if (space < 64'd8)
                        begin
                            term_valid = 1'b1;
                            term.error = asp_pkg::ERR_CONTLEN_CUT;
                        end
                        else
                        begin
                            phase_next = PH_CONTLEN;
                        end
                    end
                end
                PH_CONTLEN:
                begin
                    if (fbc_reg == 3'd7)
                    begin
                        fbc_next   = 3'd0;
                        shift_next = 64'd0;
                        if (gathered > space)
                        begin
                            term_valid = 1'b1;
                            term.error = asp_pkg::ERR_CONTENT;
                        end
                        else
                        begin
                            prim_valid      = 1'b1;
                            prim.event_code = asp_pkg::EV_CONTENT_START;
                            prim.value      = 8'd0;
                            prim.offset     = inc64[31:0];
                            prim.length     = gathered;
                            cont_rem_next   = gathered;
                            if (gathered != 64'd0)
                            begin
                                phase_next = PH_CONTENT;
                            end
                            else
                            begin
                                entry_next = entry_inc;
                                term.entry = entry_inc;
                                if (entry_last)
                                begin
                                    term_valid      = 1'b1;
                                    term.event_code = asp_pkg::EV_ACCEPT;
                                end
                                else if (space < 64'd2)
                                begin
                                    term_valid = 1'b1;
                                    term.error = asp_pkg::ERR_PATHLEN_CUT;
                                end
                                else
                                begin
                                    phase_next = PH_PATHLEN;
                                end
                            end
                        end
                    end
                    else
                    begin
                        fbc_next   = fbc_reg + 3'd1;
                        shift_next = gathered;
                    end
                end
                PH_CONTENT:
                begin
                    prim_valid      = 1'b1;
                    prim.event_code = asp_pkg::EV_CONTENT_BYTE;
                    cont_rem_next   = cont_rem_reg - 64'd1;
                    if (cont_rem_reg == 64'd1)
                    begin
                        entry_next = entry_inc;
                        term.entry = entry_inc;
                        if (entry_last)
                        begin
                            term_valid      = 1'b1;
                            term.event_code = asp_pkg::EV_ACCEPT;
                        end
                        else if (space < 64'd2)
                        begin
                            term_valid = 1'b1;
                            term.error = asp_pkg::ERR_PATHLEN_CUT;
                        end
                        else
                        begin
                            phase_next = PH_PATHLEN;
                        end
                    end
                end
                PH_DONE:
                begin
                end
            endcase
            if (term_valid)
            begin
                phase_next = PH_DONE;
            end
        end
        prim.last = !term_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MAGIC;
            fbc_reg      <= 3'd0;
            shift_reg    <= 64'd0;
            off_reg      <= '0;
            entry_reg    <= 16'd0;
            declared_reg <= 32'd0;
            path_rem_reg <= 16'd0;
            cont_rem_reg <= 64'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            fbc_reg      <= fbc_next;
            shift_reg    <= shift_next;
            off_reg      <= off_next;
            entry_reg    <= entry_next;
            declared_reg <= declared_next;
            path_rem_reg <= path_rem_next;
            cont_rem_reg <= cont_rem_next;
        end
    end

    assign push_first = prim_valid ? prim : term;
    assign push_cnt   = asp_pkg::RES_CNT_BITS'(prim_valid) + asp_pkg::RES_CNT_BITS'(term_valid);
    assign pop        = out_valid && out_ready;
    assign in_ready   = count_reg <= asp_pkg::RES_CNT_BITS'(asp_pkg::RES_FIFO_DEPTH - 2);
    assign out_valid  = count_reg != '0;

    always_ff @(posedge clk)
    begin
        if (push_cnt != '0)
        begin
            fifo_mem[wr_ptr_reg] <= push_first;
        end
        if (prim_valid && term_valid)
        begin
            fifo_mem[wr_ptr_reg + 1'b1] <= term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + asp_pkg::RES_PTR_BITS'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + asp_pkg::RES_PTR_BITS'(pop);
            count_reg  <= count_reg + push_cnt - asp_pkg::RES_CNT_BITS'(pop);
        end
    end

    assign head           = fifo_mem[rd_ptr_reg];
    assign event_res      = head.event_code;
    assign entry_index    = head.entry;
    assign byte_value     = head.value;
    assign byte_offset    = head.offset;
    assign content_length = head.length;
    assign error_code     = head.error;
    assign last_of_run    = head.last;

endmodule

### rtl/core/asp_checker.sv
// Port-level checks for the archive stream parser, bound to the top level.
module asp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  event_res,
    input logic [15:0] entry_index,
    input logic [7:0]  byte_value,
    input logic [31:0] byte_offset,
    input logic [63:0] content_length,
    input logic [3:0]  error_code,
    input logic        last_of_run
);

    logic is_end;

    assign is_end = event_res == asp_pkg::EV_ACCEPT || event_res == asp_pkg::EV_REJECT;

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res)
            && $stable(entry_index) && $stable(byte_offset) && $stable(error_code))
        else $error("stalled result changed");

    a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && is_end |=> !out_valid)
        else $error("result after accept or reject");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_end |-> last_of_run)
        else $error("accept or reject not last of run");

    a_reject_coded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == asp_pkg::EV_REJECT |-> error_code != asp_pkg::ERR_NONE
            && byte_value == 8'd0 && content_length == 64'd0)
        else $error("reject without code");

endmodule

bind archive_stream_parser asp_checker u_asp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_res      (event_res),
    .entry_index    (entry_index),
    .byte_value     (byte_value),
    .byte_offset    (byte_offset),
    .content_length (content_length),
    .error_code     (error_code),
    .last_of_run    (last_of_run)
);
